// File: rtl/core/mrs_pkg.sv
// Package for the Modbus RTU slave register server.
// Holds the sequencer state type, item mode, space and function codes, the CRC constants and the CRC step function.
// No dependencies.
package mrs_pkg;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RX,
    ST_RXEND,
    ST_CHECK,
    ST_NEXT,
    ST_LOAD,
    ST_RCRC,
    ST_PUSH,
    ST_FLUSH,
    ST_LOC,
    ST_LOCRD
  } state_e;

  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_LWR  = 2'd1;
  localparam logic [1:0] MODE_LRD  = 2'd2;

  localparam logic [1:0] SP_COIL = 2'd0;
  localparam logic [1:0] SP_DISC = 2'd1;
  localparam logic [1:0] SP_HOLD = 2'd2;
  localparam logic [1:0] SP_INP  = 2'd3;

  localparam logic [7:0] FN_RD_HOLD = 8'h03;
  localparam logic [7:0] FN_RD_INP  = 8'h04;
  localparam logic [7:0] FN_WR_COIL = 8'h05;
  localparam logic [7:0] FN_WR_HOLD = 8'h06;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Two bit steps of the reflected Modbus CRC-16.
  function automatic logic [15:0] crc_2bit(input logic [15:0] c);
    logic [15:0] t;
    t = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return t[0] ? ((t >> 1) ^ CRC_POLY) : (t >> 1);
  endfunction

endpackage

// File: rtl/core/mrs_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module mrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/core/modbus_rtu_slave_register_server.sv
// Top level of the Modbus RTU slave register server: byte intake, CRC, request handling.
// Depends on mrs_pkg and mrs_ram.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   mode, rx_byte, rx_last, space, local addr/data
//   out      output     out_valid_o / out_stall_i kind, tx chunk/count/last, read data, status
//   cfg      input      APB psel/penable/pwrite    slave_id at byte address 0
//
// For each frame byte the CRC unit folds two bits per cycle.
// Reply bytes go through the same CRC unit, CRC bytes do not; a full chunk can stall on the output.
// After reset a clearing pass zeroes all stores; no transfer is accepted meanwhile.
// Output stalls hold the sequencer; the output register still frees the input side per result.
module modbus_rtu_slave_register_server #(
  parameter int HOLDING_DEPTH  = 8192,
  parameter int INPUT_DEPTH    = 128,
  parameter int COIL_DEPTH     = 16,
  parameter int DISCRETE_DEPTH = 16,
  parameter int MAX_READ       = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        rx_last_i,
  input  logic [1:0]  space_i,
  input  logic [15:0] local_addr_i,
  input  logic [15:0] local_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic [63:0] tx_chunk_o,
  output logic [3:0]  tx_count_o,
  output logic        tx_last_o,
  output logic [15:0] read_data_o,
  output logic        access_status_o,
  output logic        holding_written_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int HAW = (HOLDING_DEPTH > 1) ? $clog2(HOLDING_DEPTH) : 1;
  localparam int IAW = (INPUT_DEPTH > 1) ? $clog2(INPUT_DEPTH) : 1;
  localparam int CAW = (COIL_DEPTH > 1) ? $clog2(COIL_DEPTH) : 1;
  localparam int DAW = (DISCRETE_DEPTH > 1) ? $clog2(DISCRETE_DEPTH) : 1;
  localparam int MAXD1 = (HOLDING_DEPTH > INPUT_DEPTH) ? HOLDING_DEPTH : INPUT_DEPTH;
  localparam int MAXD2 = (COIL_DEPTH > DISCRETE_DEPTH) ? COIL_DEPTH : DISCRETE_DEPTH;
  localparam int MAXD = (MAXD1 > MAXD2) ? MAXD1 : MAXD2;
  localparam int CW = $clog2(MAXD + 1);

  mrs_pkg::state_e state_q, state_d;

  logic [CW-1:0] clr_q, clr_d;
  logic [7:0]  id_q;
  logic [1:0]  mode_q, mode_d;
  logic [7:0]  byte_q, byte_d;
  logic        last_q, last_d;
  logic [1:0]  space_q, space_d;
  logic [15:0] la_q, la_d;
  logic [15:0] ld_q, ld_d;
  logic [7:0]  head_q [6];
  logic [7:0]  head_d [6];
  logic [8:0]  len_q, len_d;
  logic [15:0] crc_q, crc_d;
  logic [1:0]  step_q, step_d;
  logic        is_rd_q, is_rd_d;
  logic        hw_q, hw_d;
  logic [8:0]  nlen_q, nlen_d;
  logic [8:0]  bidx_q, bidx_d;
  logic [63:0] buf_q, buf_d;
  logic [3:0]  bcnt_q, bcnt_d;

  logic        ov_q, ov_d;
  logic        kind_q, kind_d;
  logic [63:0] chunk_q, chunk_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        tlast_q, tlast_d;
  logic [15:0] rdat_q, rdat_d;
  logic        stat_q, stat_d;
  logic        hwo_q, hwo_d;

  logic        in_acc, out_free, clearing;
  logic [15:0] hd_addr, hd_data, rd_word, loc_rd;
  logic [16:0] rep_addr, rd_end;
  logic [8:0]  km3;
  logic [7:0]  rep_byte;
  logic        loc_inr;

  logic            h_we, i_we, c_we, d_we;
  logic [HAW-1:0]  h_wa, h_ra;
  logic [IAW-1:0]  i_wa, i_ra;
  logic [CAW-1:0]  c_wa;
  logic [DAW-1:0]  d_wa;
  logic [15:0]     h_wd, i_wd, c_wd, d_wd, h_rd, i_rd, c_rd, d_rd;
  logic            lw_h, lw_i, lw_c, lw_d, fw_h, fw_c;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !ov_q || !out_stall_i;
  assign clearing = (state_q == mrs_pkg::ST_CLEAR);
  assign hd_addr  = {head_q[2], head_q[3]};
  assign hd_data  = {head_q[4], head_q[5]};
  assign km3      = bidx_q - 9'd3;
  assign rep_addr = {1'b0, hd_addr} + 17'(km3[8:1]);
  assign rd_end   = {1'b0, hd_addr} + {9'd0, head_q[5]};
  assign rd_word  = (head_q[1] == mrs_pkg::FN_RD_HOLD) ? h_rd : i_rd;

  always_comb begin
    case (space_q)
      mrs_pkg::SP_COIL: loc_inr = {1'b0, la_q} < 17'(COIL_DEPTH);
      mrs_pkg::SP_DISC: loc_inr = {1'b0, la_q} < 17'(DISCRETE_DEPTH);
      mrs_pkg::SP_HOLD: loc_inr = {1'b0, la_q} < 17'(HOLDING_DEPTH);
      default:          loc_inr = {1'b0, la_q} < 17'(INPUT_DEPTH);
    endcase
    case (space_q)
      mrs_pkg::SP_COIL: loc_rd = c_rd;
      mrs_pkg::SP_DISC: loc_rd = d_rd;
      mrs_pkg::SP_HOLD: loc_rd = h_rd;
      default:          loc_rd = i_rd;
    endcase
  end

  always_comb begin
    if (bidx_q == nlen_q) begin
      rep_byte = crc_q[7:0];
    end else if (bidx_q == nlen_q + 9'd1) begin
      rep_byte = crc_q[15:8];
    end else if (bidx_q == 9'd0) begin
      rep_byte = id_q;
    end else if (bidx_q == 9'd1) begin
      rep_byte = head_q[1];
    end else if (is_rd_q) begin
      if (bidx_q == 9'd2) begin
        rep_byte = {head_q[5][6:0], 1'b0};
      end else if (!km3[0]) begin
        rep_byte = rd_word[15:8];
      end else begin
        rep_byte = rd_word[7:0];
      end
    end else begin
      case (bidx_q)
        9'd2:    rep_byte = head_q[2];
        9'd3:    rep_byte = head_q[3];
        9'd4:    rep_byte = head_q[4];
        default: rep_byte = head_q[5];
      endcase
    end
  end

  // Store write ports: clearing pass, local writes and request writes.
  assign lw_c = (state_q == mrs_pkg::ST_LOC) && (mode_q == mrs_pkg::MODE_LWR) && loc_inr &&
                (space_q == mrs_pkg::SP_COIL);
  assign lw_d = (state_q == mrs_pkg::ST_LOC) && (mode_q == mrs_pkg::MODE_LWR) && loc_inr &&
                (space_q == mrs_pkg::SP_DISC);
  assign lw_h = (state_q == mrs_pkg::ST_LOC) && (mode_q == mrs_pkg::MODE_LWR) && loc_inr &&
                (space_q == mrs_pkg::SP_HOLD);
  assign lw_i = (state_q == mrs_pkg::ST_LOC) && (mode_q == mrs_pkg::MODE_LWR) && loc_inr &&
                (space_q == mrs_pkg::SP_INP);
  assign fw_c = (state_q == mrs_pkg::ST_CHECK) && (head_q[1] == mrs_pkg::FN_WR_COIL) &&
                ({1'b0, hd_addr} < 17'(COIL_DEPTH));
  assign fw_h = (state_q == mrs_pkg::ST_CHECK) && (head_q[1] == mrs_pkg::FN_WR_HOLD) &&
                ({1'b0, hd_addr} < 17'(HOLDING_DEPTH));

  assign h_we = (clearing && (32'(clr_q) < HOLDING_DEPTH)) || lw_h || fw_h;
  assign i_we = (clearing && (32'(clr_q) < INPUT_DEPTH)) || lw_i;
  assign c_we = (clearing && (32'(clr_q) < COIL_DEPTH)) || lw_c || fw_c;
  assign d_we = (clearing && (32'(clr_q) < DISCRETE_DEPTH)) || lw_d;

  assign h_wa = clearing ? clr_q[HAW-1:0] : (lw_h ? la_q[HAW-1:0] : hd_addr[HAW-1:0]);
  assign i_wa = clearing ? clr_q[IAW-1:0] : la_q[IAW-1:0];
  assign c_wa = clearing ? clr_q[CAW-1:0] : (lw_c ? la_q[CAW-1:0] : hd_addr[CAW-1:0]);
  assign d_wa = clearing ? clr_q[DAW-1:0] : la_q[DAW-1:0];

  assign h_wd = clearing ? 16'h0000 : (lw_h ? ld_q : hd_data);
  assign i_wd = clearing ? 16'h0000 : ld_q;
  assign c_wd = clearing ? 16'h0000 : (lw_c ? ld_q : hd_data);
  assign d_wd = clearing ? 16'h0000 : ld_q;

  assign h_ra = (mode_q == mrs_pkg::MODE_LRD) ? la_q[HAW-1:0] : rep_addr[HAW-1:0];
  assign i_ra = (mode_q == mrs_pkg::MODE_LRD) ? la_q[IAW-1:0] : rep_addr[IAW-1:0];

  mrs_ram #(.WIDTH(16), .DEPTH(HOLDING_DEPTH)) u_hold (
    .clk_i(clk_i), .we_i(h_we), .waddr_i(h_wa), .wdata_i(h_wd), .raddr_i(h_ra), .rdata_o(h_rd)
  );
  mrs_ram #(.WIDTH(16), .DEPTH(INPUT_DEPTH)) u_inp (
    .clk_i(clk_i), .we_i(i_we), .waddr_i(i_wa), .wdata_i(i_wd), .raddr_i(i_ra), .rdata_o(i_rd)
  );
  mrs_ram #(.WIDTH(16), .DEPTH(COIL_DEPTH)) u_coil (
    .clk_i(clk_i), .we_i(c_we), .waddr_i(c_wa), .wdata_i(c_wd), .raddr_i(la_q[CAW-1:0]),
    .rdata_o(c_rd)
  );
  mrs_ram #(.WIDTH(16), .DEPTH(DISCRETE_DEPTH)) u_disc (
    .clk_i(clk_i), .we_i(d_we), .waddr_i(d_wa), .wdata_i(d_wd), .raddr_i(la_q[DAW-1:0]),
    .rdata_o(d_rd)
  );

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    mode_d  = mode_q;
    byte_d  = byte_q;
    last_d  = last_q;
    space_d = space_q;
    la_d    = la_q;
    ld_d    = ld_q;
    head_d  = head_q;
    len_d   = len_q;
    crc_d   = crc_q;
    step_d  = step_q;
    is_rd_d = is_rd_q;
    hw_d    = hw_q;
    nlen_d  = nlen_q;
    bidx_d  = bidx_q;
    buf_d   = buf_q;
    bcnt_d  = bcnt_q;
    ov_d    = ov_q && out_stall_i;
    kind_d  = kind_q;
    chunk_d = chunk_q;
    cnt_d   = cnt_q;
    tlast_d = tlast_q;
    rdat_d  = rdat_q;
    stat_d  = stat_q;
    hwo_d   = hwo_q;

    case (state_q)
      mrs_pkg::ST_CLEAR: begin
        clr_d = clr_q + CW'(1);
        if (clr_q == CW'(MAXD - 1)) begin
          state_d = mrs_pkg::ST_IDLE;
        end
      end
      mrs_pkg::ST_IDLE: begin
        if (in_acc) begin
          mode_d  = mode_i;
          byte_d  = rx_byte_i;
          last_d  = rx_last_i;
          space_d = space_i;
          la_d    = local_addr_i;
          ld_d    = local_data_i;
          step_d  = 2'd0;
          case (mode_i)
            mrs_pkg::MODE_BYTE: begin
              if (len_q < 9'd6) begin
                head_d[len_q[2:0]] = rx_byte_i;
              end
              if (len_q != 9'd511) begin
                len_d = len_q + 9'd1;
              end
              state_d = mrs_pkg::ST_RX;
            end
            mrs_pkg::MODE_LWR, mrs_pkg::MODE_LRD: state_d = mrs_pkg::ST_LOC;
            default: state_d = mrs_pkg::ST_IDLE;
          endcase
        end
      end
      mrs_pkg::ST_RX, mrs_pkg::ST_RCRC: begin
        crc_d  = mrs_pkg::crc_2bit(crc_q ^ ((step_q == 2'd0) ? {8'h00, byte_q} : 16'h0000));
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) begin
          state_d = (state_q == mrs_pkg::ST_RX) ? mrs_pkg::ST_RXEND : mrs_pkg::ST_PUSH;
        end
      end
      mrs_pkg::ST_RXEND: begin
        if (!last_q) begin
          state_d = mrs_pkg::ST_IDLE;
        end else begin
          crc_d = mrs_pkg::CRC_INIT;
          len_d = 9'd0;
          if (len_q >= 9'd8 && crc_q == 16'h0000 && head_q[0] == id_q) begin
            state_d = mrs_pkg::ST_CHECK;
          end else begin
            state_d = mrs_pkg::ST_IDLE;
          end
        end
      end
      mrs_pkg::ST_CHECK: begin
        bidx_d  = 9'd0;
        buf_d   = 64'd0;
        bcnt_d  = 4'd0;
        state_d = mrs_pkg::ST_IDLE;
        case (head_q[1])
          mrs_pkg::FN_RD_HOLD, mrs_pkg::FN_RD_INP: begin
            is_rd_d = 1'b1;
            hw_d    = 1'b0;
            nlen_d  = 9'd3 + {head_q[5], 1'b0};
            if (32'(head_q[5]) <= MAX_READ &&
                32'(rd_end) <= ((head_q[1] == mrs_pkg::FN_RD_HOLD) ? HOLDING_DEPTH
                                                                    : INPUT_DEPTH)) begin
              state_d = mrs_pkg::ST_NEXT;
            end
          end
          mrs_pkg::FN_WR_COIL, mrs_pkg::FN_WR_HOLD: begin
            is_rd_d = 1'b0;
            hw_d    = (head_q[1] == mrs_pkg::FN_WR_HOLD);
            nlen_d  = 9'd6;
            if (fw_c || fw_h) begin
              state_d = mrs_pkg::ST_NEXT;
            end
          end
          default: state_d = mrs_pkg::ST_IDLE;
        endcase
      end
      mrs_pkg::ST_NEXT: begin
        state_d = (bidx_q == nlen_q + 9'd2) ? mrs_pkg::ST_FLUSH : mrs_pkg::ST_LOAD;
      end
      mrs_pkg::ST_LOAD: begin
        byte_d  = rep_byte;
        step_d  = 2'd0;
        state_d = (bidx_q < nlen_q) ? mrs_pkg::ST_RCRC : mrs_pkg::ST_PUSH;
      end
      mrs_pkg::ST_PUSH: begin
        if (bcnt_q == 4'd8) begin
          if (out_free) begin
            ov_d    = 1'b1;
            kind_d  = 1'b0;
            chunk_d = buf_q;
            cnt_d   = 4'd8;
            tlast_d = 1'b0;
            rdat_d  = 16'h0000;
            stat_d  = 1'b0;
            hwo_d   = hw_q;
            buf_d   = {56'd0, byte_q};
            bcnt_d  = 4'd1;
            bidx_d  = bidx_q + 9'd1;
            state_d = mrs_pkg::ST_NEXT;
          end
        end else begin
          buf_d[bcnt_q[2:0]*8 +: 8] = byte_q;
          bcnt_d  = bcnt_q + 4'd1;
          bidx_d  = bidx_q + 9'd1;
          state_d = mrs_pkg::ST_NEXT;
        end
      end
      mrs_pkg::ST_FLUSH: begin
        if (out_free) begin
          ov_d    = 1'b1;
          kind_d  = 1'b0;
          chunk_d = buf_q;
          cnt_d   = bcnt_q;
          tlast_d = 1'b1;
          rdat_d  = 16'h0000;
          stat_d  = 1'b0;
          hwo_d   = hw_q;
          crc_d   = mrs_pkg::CRC_INIT;
          state_d = mrs_pkg::ST_IDLE;
        end
      end
      mrs_pkg::ST_LOC: begin
        if (mode_q == mrs_pkg::MODE_LRD) begin
          state_d = mrs_pkg::ST_LOCRD;
        end else if (out_free) begin
          ov_d    = 1'b1;
          kind_d  = 1'b1;
          chunk_d = 64'd0;
          cnt_d   = 4'd0;
          tlast_d = 1'b0;
          rdat_d  = 16'h0000;
          stat_d  = !loc_inr;
          hwo_d   = 1'b0;
          state_d = mrs_pkg::ST_IDLE;
        end
      end
      mrs_pkg::ST_LOCRD: begin
        if (out_free) begin
          ov_d    = 1'b1;
          kind_d  = 1'b1;
          chunk_d = 64'd0;
          cnt_d   = 4'd0;
          tlast_d = 1'b0;
          rdat_d  = loc_inr ? loc_rd : 16'h0000;
          stat_d  = !loc_inr;
          hwo_d   = 1'b0;
          mode_d  = mrs_pkg::MODE_BYTE;
          state_d = mrs_pkg::ST_IDLE;
        end
      end
      default: state_d = mrs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mrs_pkg::ST_CLEAR;
      clr_q   <= '0;
      mode_q  <= mrs_pkg::MODE_BYTE;
      len_q   <= 9'd0;
      crc_q   <= mrs_pkg::CRC_INIT;
      step_q  <= 2'd0;
      ov_q    <= 1'b0;
      id_q    <= 8'd1;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      mode_q  <= mode_d;
      len_q   <= len_d;
      crc_q   <= crc_d;
      step_q  <= step_d;
      ov_q    <= ov_d;
      if (psel && penable && pwrite && !paddr[2]) begin
        id_q <= pwdata[7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    last_q  <= last_d;
    space_q <= space_d;
    la_q    <= la_d;
    ld_q    <= ld_d;
    head_q  <= head_d;
    is_rd_q <= is_rd_d;
    hw_q    <= hw_d;
    nlen_q  <= nlen_d;
    bidx_q  <= bidx_d;
    buf_q   <= buf_d;
    bcnt_q  <= bcnt_d;
    kind_q  <= kind_d;
    chunk_q <= chunk_d;
    cnt_q   <= cnt_d;
    tlast_q <= tlast_d;
    rdat_q  <= rdat_d;
    stat_q  <= stat_d;
    hwo_q   <= hwo_d;
  end

  assign in_stall_o        = (state_q != mrs_pkg::ST_IDLE);
  assign out_valid_o       = ov_q;
  assign result_kind_o     = kind_q;
  assign tx_chunk_o        = chunk_q;
  assign tx_count_o        = cnt_q;
  assign tx_last_o         = tlast_q;
  assign read_data_o       = rdat_q;
  assign access_status_o   = stat_q;
  assign holding_written_o = hwo_q;
  assign pready            = 1'b1;
  assign prdata            = (paddr == 3'd0) ? {24'd0, id_q} : 32'd0;

endmodule

// File: rtl/core/mrs_checker.sv
// Port-level checker for the Modbus RTU slave register server, bound to the top level.
// Depends on modbus_rtu_slave_register_server.
module mrs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  mode_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        result_kind_o,
  input logic [3:0]  tx_count_o,
  input logic        tx_last_o
);

  // A result waiting on a stall stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Every transfer of real work makes the block busy in the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && mode_i != 2'd3 |=> in_stall_o)
    else $error("block took work but stayed ready");

  // A reply chunk carries one to eight bytes.
  a_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !result_kind_o |-> tx_count_o != 4'd0 && tx_count_o <= 4'd8)
    else $error("bad chunk byte count");

  // A local answer carries no frame bytes.
  a_local: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o |-> tx_count_o == 4'd0 && !tx_last_o)
    else $error("local answer carries frame bytes");

endmodule

bind modbus_rtu_slave_register_server mrs_checker u_mrs_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
  .mode_i(mode_i), .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
  .result_kind_o(result_kind_o), .tx_count_o(tx_count_o), .tx_last_o(tx_last_o)
);

// File: sim/modbus_rtu_slave_register_server_test.sv
// Self-checking testbench for the Modbus RTU slave register server.
// Depends on mrs_pkg and the modbus_rtu_slave_register_server RTL.
module modbus_rtu_slave_register_server_test;

  typedef struct {
    logic [1:0]  mode;
    logic [7:0]  b;
    logic        last;
    logic [1:0]  space;
    logic [15:0] addr;
    logic [15:0] data;
  } rx_item_t;

  typedef struct {
    logic        kind;
    logic [63:0] chunk;
    logic [3:0]  count;
    logic        last;
    logic [15:0] rdata;
    logic        status;
    logic        hw;
  } reply_t;

  localparam int HOLD_N = 8192;
  localparam int INP_N  = 128;
  localparam int COIL_N = 16;
  localparam int DISC_N = 16;
  localparam int READ_MAX = 128;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_stall_o;
  logic [1:0]  mode_i;
  logic [7:0]  rx_byte_i;
  logic        rx_last_i;
  logic [1:0]  space_i;
  logic [15:0] local_addr_i, local_data_i;
  logic        out_valid_o, out_stall_i;
  logic        result_kind_o;
  logic [63:0] tx_chunk_o;
  logic [3:0]  tx_count_o;
  logic        tx_last_o;
  logic [15:0] read_data_o;
  logic        access_status_o, holding_written_o;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  modbus_rtu_slave_register_server dut (.*);

  // Predictor state.
  logic [15:0] holding_m [HOLD_N];
  logic [15:0] input_m [INP_N];
  logic [15:0] coil_m [COIL_N];
  logic [15:0] disc_m [DISC_N];
  logic [7:0]  head_m [6];
  logic [15:0] crc_m;
  int          len_m;
  logic [7:0]  station_m;

  rx_item_t pending_items[$];
  reply_t   expected_replies[$];
  rx_item_t cur;
  int send_idle_pct, recv_stall_pct, failures;
  int hold_req, hold_seen, hold_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
    c ^= {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  function automatic void push_reply(logic [7:0] buf_q[$], logic hw);
    logic [15:0] c;
    reply_t r;
    int pos;
    c = 16'hFFFF;
    foreach (buf_q[i]) c = crc_byte(c, buf_q[i]);
    buf_q.push_back(c[7:0]);
    buf_q.push_back(c[15:8]);
    pos = 0;
    while (pos < buf_q.size()) begin
      r = '{default: '0};
      r.hw = hw;
      while (r.count < 8 && pos < buf_q.size()) begin
        r.chunk[8*r.count +: 8] = buf_q[pos];
        r.count++;
        pos++;
      end
      r.last = (pos == buf_q.size());
      expected_replies.push_back(r);
    end
  endfunction

  function automatic void serve_request();
    logic [7:0]  fn, cnt;
    logic [15:0] addr, data, v;
    logic [7:0]  buf_q[$];
    fn = head_m[1];
    addr = {head_m[2], head_m[3]};
    data = {head_m[4], head_m[5]};
    cnt = head_m[5];
    if (fn == mrs_pkg::FN_RD_HOLD || fn == mrs_pkg::FN_RD_INP) begin
      if (cnt > READ_MAX) return;
      if (int'(addr) + int'(cnt) > (fn == mrs_pkg::FN_RD_HOLD ? HOLD_N : INP_N)) return;
      buf_q = '{station_m, fn, 8'(cnt * 2)};
      for (int i = 0; i < cnt; i++) begin
        v = (fn == mrs_pkg::FN_RD_HOLD) ? holding_m[addr + i] : input_m[addr + i];
        buf_q.push_back(v[15:8]);
        buf_q.push_back(v[7:0]);
      end
      push_reply(buf_q, 1'b0);
    end else if (fn == mrs_pkg::FN_WR_COIL || fn == mrs_pkg::FN_WR_HOLD) begin
      if (fn == mrs_pkg::FN_WR_COIL) begin
        if (addr >= COIL_N) return;
        coil_m[addr] = data;
      end else begin
        if (addr >= HOLD_N) return;
        holding_m[addr] = data;
      end
      buf_q = '{station_m, fn, addr[15:8], addr[7:0], data[15:8], data[7:0]};
      push_reply(buf_q, fn == mrs_pkg::FN_WR_HOLD);
    end
  endfunction

  function automatic void apply_item(rx_item_t it);
    reply_t r;
    logic ok;
    if (it.mode == mrs_pkg::MODE_BYTE) begin
      if (len_m < 6) head_m[len_m] = it.b;
      crc_m = crc_byte(crc_m, it.b);
      if (len_m < 511) len_m++;
      if (it.last) begin
        if (len_m >= 8 && crc_m == 16'h0000 && head_m[0] == station_m) serve_request();
        crc_m = 16'hFFFF;
        len_m = 0;
      end
    end else if (it.mode == mrs_pkg::MODE_LWR || it.mode == mrs_pkg::MODE_LRD) begin
      r = '{default: '0};
      r.kind = 1'b1;
      case (it.space)
        mrs_pkg::SP_COIL: ok = it.addr < COIL_N;
        mrs_pkg::SP_DISC: ok = it.addr < DISC_N;
        mrs_pkg::SP_HOLD: ok = it.addr < HOLD_N;
        default: ok = it.addr < INP_N;
      endcase
      if (!ok) r.status = 1'b1;
      else if (it.mode == mrs_pkg::MODE_LWR) begin
        case (it.space)
          mrs_pkg::SP_COIL: coil_m[it.addr] = it.data;
          mrs_pkg::SP_DISC: disc_m[it.addr] = it.data;
          mrs_pkg::SP_HOLD: holding_m[it.addr] = it.data;
          default: input_m[it.addr] = it.data;
        endcase
      end else begin
        case (it.space)
          mrs_pkg::SP_COIL: r.rdata = coil_m[it.addr];
          mrs_pkg::SP_DISC: r.rdata = disc_m[it.addr];
          mrs_pkg::SP_HOLD: r.rdata = holding_m[it.addr];
          default: r.rdata = input_m[it.addr];
        endcase
      end
      expected_replies.push_back(r);
    end
  endfunction

  // Sender.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) apply_item(cur);
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        cur = pending_items.pop_front();
        mode_i <= cur.mode;
        rx_byte_i <= cur.b;
        rx_last_i <= cur.last;
        space_i <= cur.space;
        local_addr_i <= cur.addr;
        local_data_i <= cur.data;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall, with an occasional long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    reply_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected transfer, actual kind=%0d chunk=%h", $time,
                 result_kind_o, tx_chunk_o);
        failures++;
      end else begin
        e = expected_replies.pop_front();
        if ({result_kind_o, tx_chunk_o, tx_count_o, tx_last_o, read_data_o,
             access_status_o, holding_written_o} !==
            {e.kind, e.chunk, e.count, e.last, e.rdata, e.status, e.hw}) begin
          $display("%0t: mismatch expected kind=%0d chunk=%h cnt=%0d last=%0d rd=%h st=%0d hw=%0d",
                   $time, e.kind, e.chunk, e.count, e.last, e.rdata, e.status, e.hw);
          $display("%0t:          actual kind=%0d chunk=%h cnt=%0d last=%0d rd=%h st=%0d hw=%0d",
                   $time, result_kind_o, tx_chunk_o, tx_count_o, tx_last_o, read_data_o,
                   access_status_o, holding_written_o);
          failures++;
        end
      end
    end
  end

  function automatic rx_item_t rand_item();
    rx_item_t it;
    it.mode = 2'($urandom_range(3));
    it.b = 8'($urandom);
    it.last = 1'($urandom);
    it.space = 2'($urandom);
    it.addr = 16'($urandom);
    it.data = 16'($urandom);
    return it;
  endfunction

  task automatic local_op(logic [1:0] mode, logic [1:0] space, logic [15:0] addr,
                          logic [15:0] data);
    rx_item_t it;
    it = rand_item();
    it.mode = mode;
    it.space = space;
    it.addr = addr;
    it.data = data;
    pending_items.push_back(it);
  endtask

  // Queues a frame: head bytes, filler bytes, then the CRC (corrupted if asked).
  task automatic send_frame(logic [7:0] station, logic [7:0] fn, logic [15:0] addr,
                            logic [15:0] data, int extra, bit bad_crc);
    logic [7:0]  fb[$];
    logic [15:0] c;
    rx_item_t    it;
    fb = '{station, fn, addr[15:8], addr[7:0], data[15:8], data[7:0]};
    repeat (extra) fb.push_back(8'($urandom));
    c = 16'hFFFF;
    foreach (fb[i]) c = crc_byte(c, fb[i]);
    if (bad_crc) c ^= 16'(1 << $urandom_range(15));
    fb.push_back(c[7:0]);
    fb.push_back(c[15:8]);
    foreach (fb[i]) begin
      it = rand_item();
      it.mode = mrs_pkg::MODE_BYTE;
      it.b = fb[i];
      it.last = (i == fb.size() - 1);
      pending_items.push_back(it);
    end
  endtask

  task automatic random_request();
    int sel;
    int cnt;
    logic [7:0] st;
    sel = $urandom_range(99);
    st = ($urandom_range(9) == 0) ? 8'($urandom) : station_m;
    cnt = ($urandom_range(15) == 0) ? $urandom_range(READ_MAX) : $urandom_range(6);
    if (sel < 20)
      send_frame(st, mrs_pkg::FN_RD_HOLD, 16'($urandom_range(HOLD_N - cnt)),
                 {8'($urandom), 8'(cnt)}, $urandom_range(2), $urandom_range(15) == 0);
    else if (sel < 35)
      send_frame(st, mrs_pkg::FN_RD_INP, 16'($urandom_range(INP_N + 2 - cnt)),
                 {8'($urandom), 8'(cnt)}, 0, $urandom_range(15) == 0);
    else if (sel < 47)
      send_frame(st, mrs_pkg::FN_WR_COIL, 16'($urandom_range(COIL_N)), 16'($urandom), 0,
                 $urandom_range(15) == 0);
    else if (sel < 62)
      send_frame(st, mrs_pkg::FN_WR_HOLD, ($urandom_range(9) == 0) ? 16'($urandom) :
                 16'($urandom_range(HOLD_N - 1)), 16'($urandom), 0, $urandom_range(15) == 0);
    else if (sel < 85)
      local_op(($urandom_range(1) == 0) ? mrs_pkg::MODE_LWR : mrs_pkg::MODE_LRD,
               2'($urandom),
               ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(20)),
               16'($urandom));
    else if (sel < 90)
      send_frame(st, 8'($urandom), 16'($urandom), 16'($urandom), 0, 1'b0);
    else
      repeat ($urandom_range(1, 4)) pending_items.push_back(rand_item());
  endtask

  task automatic wait_drained();
    int guard;
    while (pending_items.size() > 0 || in_valid_i || expected_replies.size() > 0)
      @(posedge clk_i);
    guard = 0;
    while (guard < 300) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  task automatic write_station(logic [7:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'd0;
    pwdata <= {24'h0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    station_m = v;
  endtask

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [7:0] stations[3];
    foreach (holding_m[i]) holding_m[i] = '0;
    foreach (input_m[i]) input_m[i] = '0;
    foreach (coil_m[i]) coil_m[i] = '0;
    foreach (disc_m[i]) disc_m[i] = '0;
    foreach (head_m[i]) head_m[i] = '0;
    crc_m = 16'hFFFF;
    len_m = 0;
    station_m = 8'd1;
    failures = 0;
    hold_req = 0;
    hold_seen = 0;
    hold_left = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_ni = 1'b0;
    {mode_i, rx_byte_i, rx_last_i, space_i, local_addr_i, local_data_i} = '0;
    {psel, penable, pwrite, paddr, pwdata} = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part with the reset station address.
    local_op(mrs_pkg::MODE_LRD, mrs_pkg::SP_HOLD, 16'd8191, 16'd0);
    local_op(mrs_pkg::MODE_LWR, mrs_pkg::SP_HOLD, 16'd8191, 16'hFFFF);
    local_op(mrs_pkg::MODE_LWR, mrs_pkg::SP_INP, 16'd127, 16'hA5A5);
    local_op(mrs_pkg::MODE_LWR, mrs_pkg::SP_COIL, 16'd15, 16'h0001);
    local_op(mrs_pkg::MODE_LWR, mrs_pkg::SP_DISC, 16'd0, 16'h8000);
    local_op(mrs_pkg::MODE_LRD, mrs_pkg::SP_DISC, 16'd0, 16'd0);
    local_op(mrs_pkg::MODE_LWR, mrs_pkg::SP_COIL, 16'd16, 16'h1234);
    local_op(mrs_pkg::MODE_LRD, mrs_pkg::SP_DISC, 16'hFFFF, 16'd0);
    local_op(mrs_pkg::MODE_LRD, mrs_pkg::SP_INP, 16'd128, 16'd0);
    local_op(mrs_pkg::MODE_LWR, mrs_pkg::SP_HOLD, 16'd8192, 16'd1);
    local_op(2'd3, mrs_pkg::SP_HOLD, 16'd0, 16'd7);
    send_frame(8'd1, mrs_pkg::FN_RD_HOLD, 16'd8190, 16'h0000, 0, 1'b0);
    send_frame(8'd1, mrs_pkg::FN_RD_HOLD, 16'd8190, 16'hFF02, 0, 1'b0);
    send_frame(8'd1, mrs_pkg::FN_RD_HOLD, 16'd8064, 16'd128, 0, 1'b0);
    send_frame(8'd1, mrs_pkg::FN_RD_HOLD, 16'd0, 16'd129, 0, 1'b0);
    send_frame(8'd1, mrs_pkg::FN_RD_INP, 16'd126, 16'd2, 0, 1'b0);
    send_frame(8'd1, mrs_pkg::FN_RD_INP, 16'd127, 16'd2, 0, 1'b0);
    send_frame(8'd1, mrs_pkg::FN_WR_COIL, 16'd15, 16'hBEEF, 0, 1'b0);
    send_frame(8'd1, mrs_pkg::FN_WR_COIL, 16'd16, 16'hBEEF, 0, 1'b0);
    send_frame(8'd1, mrs_pkg::FN_WR_HOLD, 16'd8191, 16'hFFFF, 0, 1'b0);
    send_frame(8'd1, mrs_pkg::FN_WR_HOLD, 16'd8192, 16'h0001, 0, 1'b0);
    send_frame(8'd1, 8'h10, 16'd0, 16'd1, 0, 1'b0);
    send_frame(8'd1, mrs_pkg::FN_WR_HOLD, 16'd3, 16'd3, 0, 1'b1);
    send_frame(8'd2, mrs_pkg::FN_WR_HOLD, 16'd3, 16'd3, 0, 1'b0);
    send_frame(8'd1, mrs_pkg::FN_WR_HOLD, 16'd3, 16'd3, 4, 1'b0);
    begin
      rx_item_t it;
      it = rand_item();
      it.mode = mrs_pkg::MODE_BYTE;
      it.last = 1'b0;
      repeat (5) pending_items.push_back(it);
      it.last = 1'b1;
      pending_items.push_back(it);
    end
    wait_drained();

    stations = '{8'd255, 8'($urandom), 8'd1};
    foreach (stations[p]) begin
      write_station(stations[p]);
      send_frame(stations[p], mrs_pkg::FN_WR_HOLD, 16'd5, 16'($urandom), 0, 1'b0);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      random_request();
      wait_drained();
      send_idle_pct = 52;
      random_request();
      wait_drained();
      send_idle_pct = 0;
      recv_stall_pct = 52;
      random_request();
      wait_drained();
      send_idle_pct = 17;
      recv_stall_pct = 17;
      if (p == 1) begin
        hold_req++;
        send_frame(stations[p], mrs_pkg::FN_RD_HOLD, 16'd0, 16'd6, 0, 1'b0);
        local_op(mrs_pkg::MODE_LRD, mrs_pkg::SP_HOLD, 16'd5, 16'd0);
      end
      random_request();
      wait_drained();
    end

    if (failures == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
